// ===== src/tts_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the task scheduler.
`default_nettype none
package tts_pkg;

  localparam int TASK_COUNT = 8;
  localparam int SLOT_W     = 3;

  localparam int OPCODE_W = 3;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 16;
  localparam int PEND_W   = 8;
  localparam int KIND_W   = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CREATE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SETSTATE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH = 3'd4;

  localparam logic [KIND_W-1:0] KIND_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // register index is byte address / 4
  localparam logic REG_TICK_STEP = 1'b0;

  typedef struct packed {
    logic load_req;
    logic cnt_clr;
    logic cnt_inc;
    logic tick_upd;
    logic cmd_exec;
    logic disp_emit;
    logic none_emit;
  } tts_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic slot_run;
    logic run_later;
    logic any_run;
  } tts_stat_t;

endpackage
`default_nettype wire

// ===== src/tts_req_if.sv =====
// Request channel: valid/ready handshake carrying one scheduler request.
`default_nettype none
interface tts_req_if;
  logic                          valid;
  logic                          ready;
  logic [tts_pkg::OPCODE_W-1:0]  opcode;
  logic [tts_pkg::ID_W-1:0]      task_id;
  logic [tts_pkg::TIME_W-1:0]    initial_delay;
  logic [tts_pkg::TIME_W-1:0]    reload_period;
  logic                          has_handler;
  logic                          suspend;

  modport source (
    output valid, opcode, task_id, initial_delay, reload_period, has_handler, suspend,
    input  ready
  );
  modport sink (
    input  valid, opcode, task_id, initial_delay, reload_period, has_handler, suspend,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/tts_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one scheduler result.
`default_nettype none
interface tts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::KIND_W-1:0]  result_kind;
  logic [tts_pkg::SLOT_W-1:0]  run_task;
  logic                        last;

  modport source (output valid, result_kind, run_task, last, input ready);
  modport sink   (input  valid, result_kind, run_task, last, output ready);
endinterface
`default_nettype wire

// ===== src/tts_cfg.sv =====
// APB-style configuration register block holding the tick step.
`default_nettype none
module tts_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tts_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [tts_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [tts_pkg::TIME_W-1:0]      tick_step
);
  import tts_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TIME_W'(1);
    end else if (wr_en && (paddr[CFG_ADDR_W-1] == REG_TICK_STEP)) begin
      tick_step <= pwdata[TIME_W-1:0];
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1] == REG_TICK_STEP) begin
      prdata = {{(CFG_DATA_W-TIME_W){1'b0}}, tick_step};
    end else begin
      prdata = '0;
    end
  end
endmodule
`default_nettype wire

// ===== src/tts_ctrl.sv =====
// Scheduler controller: sequences tick scans, single commands and dispatch scans.
`default_nettype none
module tts_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  input  wire logic [tts_pkg::OPCODE_W-1:0]   req_opcode,
  output logic                                req_ready,
  input  wire tts_pkg::tts_stat_t             stat,
  output tts_pkg::tts_cmd_t                   cmd
);
  import tts_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_CMD  = 2'd2;
  localparam logic [1:0] S_DISP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          cmd.cnt_clr  = 1'b1;
          if (req_opcode == OP_TICK) begin
            state_next = S_TICK;
          end else if (req_opcode == OP_DISPATCH) begin
            state_next = S_DISP;
          end else begin
            state_next = S_CMD;
          end
        end
      end
      S_TICK: begin
        cmd.tick_upd = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_CMD: begin
        if (stat.out_free) begin
          cmd.cmd_exec = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DISP: begin
        if (!stat.any_run) begin
          if (stat.out_free) begin
            cmd.none_emit = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (stat.slot_run) begin
          if (stat.out_free) begin
            cmd.disp_emit = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (!stat.run_later) begin
              state_next = S_IDLE;
            end
          end
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.tick_upd, cmd.cmd_exec, cmd.disp_emit, cmd.none_emit}))
    else $error("more than one datapath action in a cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.cmd_exec || cmd.disp_emit || cmd.none_emit) |-> stat.out_free)
    else $error("result emitted into a full output register");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !(cmd.tick_upd || cmd.cmd_exec || cmd.disp_emit || cmd.none_emit))
    else $error("datapath action while accepting a request");

  a_tick_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK && stat.cnt_last) |=> (state == S_IDLE))
    else $error("tick scan did not finish on the last slot");

  a_disp_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.disp_emit && !stat.run_later) |=> req_ready)
    else $error("dispatch continued after its final result");
endmodule
`default_nettype wire

// ===== src/tts_dp.sv =====
// Scheduler datapath: task table, slot counter, request latch and result register.
`default_nettype none
module tts_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tts_pkg::tts_cmd_t              cmd,
  output tts_pkg::tts_stat_t                  stat,
  input  wire logic [tts_pkg::TIME_W-1:0]     tick_step,
  input  wire logic [tts_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic [tts_pkg::ID_W-1:0]       task_id,
  input  wire logic [tts_pkg::TIME_W-1:0]     initial_delay,
  input  wire logic [tts_pkg::TIME_W-1:0]     reload_period,
  input  wire logic                           has_handler,
  input  wire logic                           suspend,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [tts_pkg::KIND_W-1:0]     result_kind,
  output logic      [tts_pkg::SLOT_W-1:0]     run_task,
  output logic                                last
);
  import tts_pkg::*;

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // request latch
  logic [OPCODE_W-1:0] op_q;
  logic [ID_W-1:0]     id_q;
  logic [TIME_W-1:0]   delay_q;
  logic [TIME_W-1:0]   period_q;
  logic                handler_q;
  logic                susp_q;

  // task table
  logic [TIME_W-1:0]     countdown [TASK_COUNT];
  logic [TIME_W-1:0]     reload    [TASK_COUNT];
  logic [TASK_COUNT-1:0] present;
  logic [TASK_COUNT-1:0] suspended;
  logic [PEND_W-1:0]     pending   [TASK_COUNT];

  logic [SLOT_W-1:0]     cnt;
  logic [SLOT_W-1:0]     slot;
  logic [TASK_COUNT-1:0] runnable;
  logic [TASK_COUNT-1:0] above;
  logic                  id_ok;
  logic                  cmd_ok;
  logic                  tick_live;
  logic [TIME_W-1:0]     cd_next;
  logic [PEND_W-1:0]     pend_inc;

  assign id_ok = (id_q < ID_W'(TASK_COUNT));
  assign slot  = cmd.cmd_exec ? id_q[SLOT_W-1:0] : cnt;

  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      runnable[i] = present[i] && (pending[i] != '0);
      above[i]    = (SLOT_W'(i) > cnt);
    end
  end

  always_comb begin
    unique case (op_q)
      OP_CREATE:   cmd_ok = id_ok;
      OP_DELETE:   cmd_ok = id_ok && present[slot];
      OP_SETSTATE: cmd_ok = id_ok && present[slot];
      default:     cmd_ok = 1'b0;
    endcase
  end

  assign tick_live = present[slot] && !suspended[slot];
  assign pend_inc  = (pending[slot] != '1) ? (pending[slot] + PEND_W'(1)) : pending[slot];

  always_comb begin
    if (countdown[slot] == '0) begin
      cd_next = (reload[slot] != '0) ? sat_sub(reload[slot], tick_step) : countdown[slot];
    end else begin
      cd_next = sat_sub(countdown[slot], tick_step);
    end
  end

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.cnt_last  = (cnt == SLOT_W'(TASK_COUNT - 1));
  assign stat.slot_run  = runnable[cnt];
  assign stat.run_later = |(runnable & above);
  assign stat.any_run   = |runnable;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q      <= opcode;
      id_q      <= task_id;
      delay_q   <= initial_delay;
      period_q  <= reload_period;
      handler_q <= has_handler;
      susp_q    <= suspend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + SLOT_W'(1);
    end
  end

  // flags and run counts
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      suspended <= '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
        pending[i] <= '0;
      end
    end else if (cmd.tick_upd) begin
      if (tick_live && (countdown[slot] == '0)) begin
        pending[slot] <= pend_inc;
      end
    end else if (cmd.disp_emit) begin
      pending[slot] <= pending[slot] - PEND_W'(1);
    end else if (cmd.cmd_exec && cmd_ok) begin
      unique case (op_q)
        OP_CREATE: begin
          present[slot]   <= handler_q;
          suspended[slot] <= 1'b0;
          pending[slot]   <= '0;
        end
        OP_DELETE: begin
          present[slot] <= 1'b0;
          pending[slot] <= '0;
        end
        default: begin
          suspended[slot] <= susp_q;
        end
      endcase
    end
  end

  // timing fields
  always_ff @(posedge clk) begin
    if (cmd.tick_upd) begin
      if (tick_live) begin
        countdown[slot] <= cd_next;
      end
    end else if (cmd.cmd_exec && cmd_ok) begin
      if (op_q == OP_CREATE) begin
        countdown[slot] <= delay_q;
        reload[slot]    <= period_q;
      end else if (op_q == OP_DELETE) begin
        countdown[slot] <= '0;
        reload[slot]    <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.cmd_exec || cmd.disp_emit || cmd.none_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_exec) begin
      result_kind <= cmd_ok ? KIND_OK : KIND_ERR;
      run_task    <= '0;
      last        <= 1'b1;
    end else if (cmd.disp_emit) begin
      result_kind <= KIND_RUN;
      run_task    <= cnt;
      last        <= !stat.run_later;
    end else if (cmd.none_emit) begin
      result_kind <= KIND_NONE;
      run_task    <= '0;
      last        <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== src/time_triggered_task_scheduler_core.sv =====
// Time-triggered task scheduler top level: eight task slots, APB tick-step register.
// Tick: one slot per cycle through the shared update unit, every slot in turn, no result.
// Create/delete/set state and spare opcodes: one result, once the output register is free.
// Dispatch: slot scan, one result per pending slot, each once the output register is free.
// The next request is taken while the last result still waits in the output register.
// Reset (rst, synchronous): all slots absent, ready, no pending runs; tick step 1.
`default_nettype none
module time_triggered_task_scheduler_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tts_req_if.sink                              req,
  tts_rsp_if.source                            rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tts_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [tts_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import tts_pkg::*;

  tts_cmd_t          cmd;
  tts_stat_t         stat;
  logic [TIME_W-1:0] tick_step;
  logic              req_ready;

  assign req.ready = req_ready;

  tts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tick_step (tick_step)
  );

  tts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .tick_step     (tick_step),
    .opcode        (req.opcode),
    .task_id       (req.task_id),
    .initial_delay (req.initial_delay),
    .reload_period (req.reload_period),
    .has_handler   (req.has_handler),
    .suspend       (req.suspend),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .result_kind   (rsp.result_kind),
    .run_task      (rsp.run_task),
    .last          (rsp.last)
  );
endmodule
`default_nettype wire

// ===== dv/tts_sched_checker.sv =====
// Scoreboard for the task scheduler: predicts results from accepted requests and checks them.
`timescale 1ns / 100ps
module tts_sched_checker (
  input  logic                           clk,
  input  logic                           rst,
  tts_req_if                             req,
  tts_rsp_if                             rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [tts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tts_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             mismatches,
  output int                             outstanding
);
  import tts_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } sched_result_t;

  logic [TIME_W-1:0] countdown [TASK_COUNT];
  logic [TIME_W-1:0] period_q  [TASK_COUNT];
  logic              alive     [TASK_COUNT];
  logic              held      [TASK_COUNT];
  logic [PEND_W-1:0] runs      [TASK_COUNT];
  logic [TIME_W-1:0] step;
  sched_result_t     due_results [$];

  function automatic logic [TIME_W-1:0] floor_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic push_result(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                             input logic last);
    sched_result_t r;
    r.kind = kind;
    r.slot = slot;
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic schedule_request(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                                  input logic [TIME_W-1:0] delay,
                                  input logic [TIME_W-1:0] period,
                                  input logic handler, input logic susp);
    int   i;
    int   t;
    int   final_slot;
    logic id_ok;
    id_ok = id < TASK_COUNT;
    t = id_ok ? int'(id) : 0;
    final_slot = -1;
    case (op)
      OP_TICK: begin
        for (i = 0; i < TASK_COUNT; i++) begin
          if (alive[i] && !held[i]) begin
            if (countdown[i] == '0) begin
              if (runs[i] != '1) runs[i] = runs[i] + 1'b1;
              if (period_q[i] != '0) countdown[i] = floor_sub(period_q[i], step);
            end else begin
              countdown[i] = floor_sub(countdown[i], step);
            end
          end
        end
      end
      OP_CREATE: begin
        if (!id_ok) begin
          push_result(KIND_ERR, '0, 1'b1);
        end else begin
          countdown[t] = delay;
          period_q[t] = period;
          alive[t] = handler;
          held[t] = 1'b0;
          runs[t] = '0;
          push_result(KIND_OK, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (!id_ok || !alive[t]) begin
          push_result(KIND_ERR, '0, 1'b1);
        end else begin
          countdown[t] = '0;
          period_q[t] = '0;
          alive[t] = 1'b0;
          runs[t] = '0;
          push_result(KIND_OK, '0, 1'b1);
        end
      end
      OP_SETSTATE: begin
        if (!id_ok || !alive[t]) begin
          push_result(KIND_ERR, '0, 1'b1);
        end else begin
          held[t] = susp;
          push_result(KIND_OK, '0, 1'b1);
        end
      end
      OP_DISPATCH: begin
        for (i = 0; i < TASK_COUNT; i++)
          if (alive[i] && runs[i] != '0) final_slot = i;
        if (final_slot < 0) begin
          push_result(KIND_NONE, '0, 1'b1);
        end else begin
          for (i = 0; i < TASK_COUNT; i++) begin
            if (alive[i] && runs[i] != '0) begin
              runs[i] = runs[i] - 1'b1;
              push_result(KIND_RUN, SLOT_W'(i), i == final_slot);
            end
          end
        end
      end
      default: push_result(KIND_ERR, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        countdown[i] = '0;
        period_q[i] = '0;
        alive[i] = 1'b0;
        held[i] = 1'b0;
        runs[i] = '0;
      end
      step = TIME_W'(1);
      mismatches = 0;
      due_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, kind %0d task %0d last %0b", $time,
                   rsp.result_kind, rsp.run_task, rsp.last);
        end else begin
          want = due_results.pop_front();
          if (rsp.result_kind !== want.kind) begin
            mismatches++;
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                     rsp.result_kind);
          end
          if (rsp.run_task !== want.slot) begin
            mismatches++;
            $display("%0t: run_task expected %0d actual %0d", $time, want.slot, rsp.run_task);
          end
          if (rsp.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, rsp.last);
          end
        end
      end
      if (req.valid && req.ready)
        schedule_request(req.opcode, req.task_id, req.initial_delay, req.reload_period,
                         req.has_handler, req.suspend);
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_TICK_STEP)
        step = pwdata[TIME_W-1:0];
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== dv/tb_time_triggered_task_scheduler_core.sv =====
// Testbench top for the task scheduler: request stimulus, tick-step set-up and verdict.
`timescale 1ns / 100ps
module tb_time_triggered_task_scheduler_core;
  import tts_pkg::*;

  localparam int RANDOM_ITEMS = 70;
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 2 * TASK_COUNT + 4;
  localparam int LONG_HOLD    = 400;
  localparam int SAT_TICKS    = 260;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = OP_DISPATCH + 1'b1;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = '1;
  localparam logic [TIME_W-1:0]   TIME_MAX    = '1;
  localparam logic [ID_W-1:0]     ID_MAX      = '1;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  stall_long;
  int                    mismatches;
  int                    outstanding;
  int                    burst_left;

  tts_req_if req_ch ();
  tts_rsp_if rsp_ch ();

  time_triggered_task_scheduler_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tts_sched_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: changing stall patterns, plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_long && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= $urandom_range(0, 1) == 0;
          2:       rsp_ch.ready <= $urandom_range(0, 3) == 0;
          default: rsp_ch.ready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return TIME_W'($urandom_range(0, TIME_MAX));
      default: return TIME_W'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] period,
                          input logic handler, input logic susp);
    int gap;
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.task_id       <= id;
    req_ch.initial_delay <= delay;
    req_ch.reload_period <= period;
    req_ch.has_handler   <= handler;
    req_ch.suspend       <= susp;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_request();
    int                  pick;
    logic [OPCODE_W-1:0] op;
    logic [ID_W-1:0]     id;
    pick = $urandom_range(0, 99);
    if (pick < 34)      op = OP_TICK;
    else if (pick < 52) op = OP_CREATE;
    else if (pick < 62) op = OP_DELETE;
    else if (pick < 74) op = OP_SETSTATE;
    else if (pick < 97) op = OP_DISPATCH;
    else                op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, ID_MAX))
                                     : ID_W'($urandom_range(0, TASK_COUNT - 1));
    send_req(op, id, pick_time(), pick_time(), $urandom_range(0, 7) != 0,
             $urandom_range(0, 2) == 0);
  endtask

  // stop sending and let every outstanding result and any tick scan finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_step(input logic [TIME_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[TIME_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICK_STEP, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int k;
    int op;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_TICK;
    req_ch.task_id       <= '0;
    req_ch.initial_delay <= '0;
    req_ch.reload_period <= '0;
    req_ch.has_handler   <= 1'b0;
    req_ch.suspend       <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    stall_long           <= 1'b0;
    burst_left = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty dispatch, id bounds, absent slots, suspend, spare opcodes
    send_req(OP_DISPATCH, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_CREATE, 0, 0, 0, 1'b1, 1'b0);
    send_req(OP_CREATE, ID_W'(TASK_COUNT - 1), TIME_MAX, TIME_MAX, 1'b1, 1'b1);
    send_req(OP_CREATE, ID_W'(TASK_COUNT), 7, 7, 1'b1, 1'b0);
    send_req(OP_CREATE, ID_MAX, TIME_MAX, TIME_MAX, 1'b1, 1'b1);
    send_req(OP_CREATE, 3, 5, 5, 1'b0, 1'b0);
    send_req(OP_DELETE, 3, 0, 0, 1'b1, 1'b0);
    send_req(OP_SETSTATE, 3, 0, 0, 1'b1, 1'b1);
    send_req(OP_SETSTATE, ID_MAX, 0, 0, 1'b1, 1'b1);
    send_req(OP_DELETE, ID_W'(TASK_COUNT), 0, 0, 1'b1, 1'b0);
    send_req(OP_CREATE, 1, 1, 2, 1'b1, 1'b0);
    repeat (3) send_req(OP_TICK, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_DISPATCH, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_SETSTATE, 1, 0, 0, 1'b0, 1'b1);
    send_req(OP_TICK, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_DISPATCH, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_SETSTATE, 1, 0, 0, 1'b0, 1'b0);
    for (op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      send_req(OPCODE_W'(op), 1, TIME_MAX, TIME_MAX, 1'b1, 1'b1);
    send_req(OP_DELETE, 0, 0, 0, 1'b0, 1'b0);
    for (k = 2; k < TASK_COUNT - 1; k++)
      send_req(OP_CREATE, ID_W'(k), 0, 1, 1'b1, 1'b0);
    repeat (2) send_req(OP_TICK, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_DISPATCH, 0, 0, 0, 1'b0, 1'b0);

    // pending count runs into its ceiling
    send_req(OP_CREATE, 2, 0, 0, 1'b1, 1'b0);
    repeat (SAT_TICKS) send_req(OP_TICK, 0, 0, 0, 1'b0, 1'b0);
    repeat (2) send_req(OP_DISPATCH, 0, 0, 0, 1'b0, 1'b0);
    repeat (3) send_req(OP_TICK, 0, 0, 0, 1'b0, 1'b0);
    send_req(OP_DISPATCH, 0, 0, 0, 1'b0, 1'b0);

    for (k = 0; k < PHASES; k++) begin
      settle();
      case (k)
        0:       write_tick_step(TIME_MAX);
        1:       write_tick_step('0);
        2:       write_tick_step(TIME_W'(1));
        3:       write_tick_step(TIME_W'($urandom_range(2, 9)));
        default: write_tick_step(TIME_W'($urandom_range(1, TIME_MAX)));
      endcase
      if (k == 2) stall_long <= 1'b1;
      repeat (RANDOM_ITEMS / PHASES) send_random_request();
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
